@@ src/muxbus_master_sequencer_unit_macros.svh @@
// Assertion macros shared by the checker of the multiplexed bus master sequencer.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef MUXBUS_MASTER_SEQUENCER_UNIT_MACROS_SVH
`define MUXBUS_MASTER_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MBMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbms: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define MBMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbms: next-cycle check failed");

`endif

@@ src/mbms_pkg.sv @@
// Package for the multiplexed bus master sequencer: phase codes, register
// indexes, reset values and the request/result/view structs. No dependencies.
package mbms_pkg;

	localparam int unsigned TIMING_WIDTH_DEF = 8;
	localparam int unsigned CFG_DATA_W       = 8;
	localparam int unsigned CFG_IDX_W        = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALE_PULSE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_HOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CS_PULSE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_HOLD    = 3'd4;
	localparam int unsigned          NUM_CFG          = 5;

	// Reset values of the timing registers
	localparam logic [CFG_DATA_W-1:0] RST_ALE_PULSE    = 8'd7;
	localparam logic [CFG_DATA_W-1:0] RST_ADDRESS_HOLD = 8'd7;
	localparam logic [CFG_DATA_W-1:0] RST_DATA_SETUP   = 8'd7;
	localparam logic [CFG_DATA_W-1:0] RST_CS_PULSE     = 8'd67;
	localparam logic [CFG_DATA_W-1:0] RST_DATA_HOLD    = 8'd15;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ALE   = 3'd1,
		PH_AHOLD = 3'd2,
		PH_SETUP = 3'd3,
		PH_CS    = 3'd4,
		PH_DHOLD = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef struct packed {
		logic        start_req;
		logic        command;
		logic [15:0] address;
		logic [15:0] write_data;
		logic [15:0] bus_ad_in;
	} request_t;

	typedef struct packed {
		logic        ale_n;
		logic        cs_n;
		logic        dir_line;
		logic [15:0] ad_out;
		logic        ad_drive;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} result_t;

	// Sequencer state as seen by the pin decoder
	typedef struct packed {
		phase_t      phase;
		logic        command;
		logic        direction;
		logic [15:0] address;
		logic [15:0] write_data;
		logic [15:0] read_data;
	} view_t;

endpackage

@@ src/mbms_decode.sv @@
// Pin decoder: turns the sequencer state into bus strobes and AD drive.
// Depends on mbms_pkg.
module mbms_decode (
	input  mbms_pkg::view_t   view,
	output mbms_pkg::result_t pins
);
	import mbms_pkg::*;

	always_comb begin
		pins           = '0;
		pins.ale_n     = 1'b1;
		pins.cs_n      = 1'b1;
		pins.dir_line  = view.direction;
		pins.read_data = view.read_data;
		case (view.phase)
			PH_ALE: begin
				pins.ale_n    = 1'b0;
				pins.ad_drive = 1'b1;
				pins.ad_out   = view.address;
				pins.busy_res = 1'b1;
			end
			PH_AHOLD: begin
				pins.ad_drive = 1'b1;
				pins.ad_out   = view.address;
				pins.busy_res = 1'b1;
			end
			PH_SETUP, PH_CS, PH_DHOLD: begin
				pins.cs_n     = (view.phase != PH_CS);
				pins.busy_res = 1'b1;
				// release AD for a read, drive write data otherwise
				if (!view.command) begin
					pins.ad_drive = 1'b1;
					pins.ad_out   = view.write_data;
				end
			end
			PH_DONE: begin
				pins.done_res = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/muxbus_master_sequencer_unit.sv @@
// Top level of the multiplexed address/data bus master sequencer.
// Depends on mbms_pkg and mbms_decode.
//
// Usage
//  - Each request is one bus clock tick: start_req/command/address/write_data
//    start a transaction when the sequencer is idle, bus_ad_in carries the
//    sampled AD lines every tick. Every request yields exactly one result that
//    shows the pin levels (ALE#, CS#, DIR, AD drive) after that tick.
//  - Channels use valid/stall. A request is taken at a clock edge with
//    request_valid high and request_stall low; a result likewise on the
//    result side.
//  - The result of a request is written to the output register at the same
//    edge that takes it. Throughput: one request per cycle while the result
//    side does not stall, set by the single state update plus decode between
//    the state registers and the output register.
//  - When the receiver stalls, the held result stays put and request_stall
//    rises in the same cycle; the tick sequence simply pauses, no tick lost.
//  - Timing registers are written through cfg_we/cfg_index/cfg_data by the
//    user only while no transaction is pending; the block does not enforce
//    this. A zero value acts as one, and indexes past data hold are dropped.
//  - Reset clears phase to idle, counters and latched values to zero, the
//    direction line to write and the timing registers to their defaults.
module muxbus_master_sequencer_unit #(
	parameter int unsigned TIMING_WIDTH = mbms_pkg::TIMING_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              request_valid,
	output logic                              request_stall,
	input  mbms_pkg::request_t                request,
	output logic                              result_valid,
	input  logic                              result_stall,
	output mbms_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [mbms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbms_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mbms_pkg::*;

	// Registers keep only the low bits the counter can hold, never above 8.
	localparam int unsigned CFG_W = (TIMING_WIDTH < CFG_DATA_W) ? TIMING_WIDTH : CFG_DATA_W;

	logic [CFG_W-1:0]        cfg_q [NUM_CFG];

	phase_t                  phase_q, phase_n;
	logic [TIMING_WIDTH-1:0] cnt_q, cnt_n, cnt_dec, cnt_load;
	logic                    cmd_q, cmd_n;
	logic                    dir_q, dir_n;
	logic [15:0]             addr_q, addr_n;
	logic [15:0]             wdata_q, wdata_n;
	logic [15:0]             rdata_q, rdata_n;

	phase_t                  follow;     // phase entered when the count runs out
	logic [CFG_W-1:0]        cfg_sel;
	logic                    accept;
	logic                    result_valid_q;
	result_t                 result_q;
	result_t                 pins;
	view_t                   view_n;

	// Handshake: take a request whenever the output register is free or
	// being emptied this cycle.
	assign request_stall = result_valid_q & result_stall;
	assign accept        = request_valid & ~request_stall;
	assign result_valid  = result_valid_q;
	assign result        = result_q;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CFG_ALE_PULSE]    <= CFG_W'(RST_ALE_PULSE);
			cfg_q[CFG_ADDRESS_HOLD] <= CFG_W'(RST_ADDRESS_HOLD);
			cfg_q[CFG_DATA_SETUP]   <= CFG_W'(RST_DATA_SETUP);
			cfg_q[CFG_CS_PULSE]     <= CFG_W'(RST_CS_PULSE);
			cfg_q[CFG_DATA_HOLD]    <= CFG_W'(RST_DATA_HOLD);
		end else if (cfg_we && cfg_index <= CFG_DATA_HOLD) begin
			cfg_q[cfg_index] <= cfg_data[CFG_W-1:0];
		end
	end

	// Phase that follows the current one
	always_comb begin
		case (phase_q)
			PH_IDLE:  follow = PH_ALE;
			PH_ALE:   follow = PH_AHOLD;
			PH_AHOLD: follow = PH_SETUP;
			PH_SETUP: follow = PH_CS;
			PH_CS:    follow = PH_DHOLD;
			PH_DHOLD: follow = PH_DONE;
			default:  follow = PH_IDLE;
		endcase
	end

	// Count loaded on entry to the following phase; zero acts as one
	always_comb begin
		case (follow)
			PH_ALE:   cfg_sel = cfg_q[CFG_ALE_PULSE];
			PH_AHOLD: cfg_sel = cfg_q[CFG_ADDRESS_HOLD];
			PH_SETUP: cfg_sel = cfg_q[CFG_DATA_SETUP];
			PH_CS:    cfg_sel = cfg_q[CFG_CS_PULSE];
			PH_DHOLD: cfg_sel = cfg_q[CFG_DATA_HOLD];
			default:  cfg_sel = '0;
		endcase
		if (follow == PH_DONE) begin
			cnt_load = TIMING_WIDTH'(1);
		end else if (follow == PH_IDLE) begin
			cnt_load = '0;
		end else if (cfg_sel == '0) begin
			cnt_load = TIMING_WIDTH'(1);
		end else begin
			cnt_load = TIMING_WIDTH'(cfg_sel);
		end
	end

	// Next state for one tick
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		cmd_n   = cmd_q;
		dir_n   = dir_q;
		addr_n  = addr_q;
		wdata_n = wdata_q;
		rdata_n = rdata_q;
		cnt_dec = cnt_q - TIMING_WIDTH'(1);
		case (phase_q)
			PH_IDLE: begin
				// latch the transaction and open the address phase
				if (request.start_req) begin
					cmd_n   = request.command;
					dir_n   = request.command;
					addr_n  = request.address;
					wdata_n = request.write_data;
					phase_n = follow;
					cnt_n   = cnt_load;
				end
			end
			PH_ALE, PH_AHOLD, PH_SETUP, PH_CS, PH_DHOLD, PH_DONE: begin
				cnt_n = cnt_dec;
				if (cnt_dec == '0) begin
					// sample AD on the tick that ends the CS# pulse of a read
					if (phase_q == PH_CS && cmd_q) begin
						rdata_n = request.bus_ad_in;
					end
					phase_n = follow;
					cnt_n   = cnt_load;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			cmd_q   <= 1'b0;
			dir_q   <= 1'b0;
			addr_q  <= '0;
			wdata_q <= '0;
			rdata_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			cmd_q   <= cmd_n;
			dir_q   <= dir_n;
			addr_q  <= addr_n;
			wdata_q <= wdata_n;
			rdata_q <= rdata_n;
		end
	end

	// Pins reflect the state after this tick's update
	always_comb begin
		view_n.phase      = phase_n;
		view_n.command    = cmd_n;
		view_n.direction  = dir_n;
		view_n.address    = addr_n;
		view_n.write_data = wdata_n;
		view_n.read_data  = rdata_n;
	end

	mbms_decode u_decode (
		.view (view_n),
		.pins (pins)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= pins;
		end
	end

endmodule

@@ src/mbms_checker.sv @@
// Port-level checker for the multiplexed bus master sequencer, bound to the top.
// Depends on mbms_pkg and muxbus_master_sequencer_unit_macros.svh.
`include "muxbus_master_sequencer_unit_macros.svh"

module mbms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input mbms_pkg::result_t result
);
	import mbms_pkg::*;

	// hold a stalled result
	`MBMS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	// done tick: bus released and not busy
	`MBMS_ASSERT_NOW(a_done_idle, result_valid && result.done_res, !result.busy_res && !result.ad_drive)
	// address phase: address driven, chip select off
	`MBMS_ASSERT_NOW(a_ale_phase, result_valid && !result.ale_n, result.cs_n && result.ad_drive && result.busy_res)
	// strobes never overlap, and CS# only inside a transaction
	`MBMS_ASSERT_NOW(a_cs_phase, result_valid && !result.cs_n, result.ale_n && result.busy_res)
	// released AD reads as zero
	`MBMS_ASSERT_NOW(a_ad_release, result_valid && !result.ad_drive, result.ad_out == 16'd0)

endmodule

bind muxbus_master_sequencer_unit mbms_checker u_mbms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
